// ----- design/command_line_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// command_line_tokenizer_macros.svh
// Assertion helpers for the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CLTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CLTOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cltok_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_pkg
// Types and constants shared by the command line tokenizer.
// ----------------------------------------------------------------------------
package cltok_pkg;

  // Default token limit per line
  localparam int MAX_TOKENS_DEFAULT = 64;

  // Results one byte can produce, and the width of an index into them
  localparam int RES_MAX   = 3;
  localparam int RES_IDX_W = 2;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    MODE_WS     = 3'd0,
    MODE_TOKEN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_DONE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_END_TOKEN = 2'd1,
    KIND_END_LINE  = 2'd2
  } kind_t;

  // Parser flags carried from byte to byte
  typedef struct packed {
    mode_t mode;
    logic  slash;
    logic  star;
  } flags_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [5:0]  token_number;
    logic [6:0]  token_count;
  } result_t;

endpackage

// ----- design/cltok_char_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_char_if
// Valid/ready channel carrying one command line byte per transaction.
// ----------------------------------------------------------------------------
interface cltok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// ----- design/cltok_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_res_if
// Valid/ready channel carrying one tokenizer result per transaction.
// ----------------------------------------------------------------------------
interface cltok_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [5:0] token_number;
  logic [6:0] token_count;
  logic       last;

  modport source (output valid, output kind, output value, output token_number,
                  output token_count, output last, input ready);
  modport sink (input valid, input kind, input value, input token_number,
                input token_count, input last, output ready);
endinterface

// ----- design/cltok_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_step
// Parser step for one byte: next flags, next token count and up to three
// results in transaction order.
// ----------------------------------------------------------------------------
module cltok_step import cltok_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEFAULT,
  parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
  input  flags_t               cur_flags,
  input  logic [CNT_W-1:0]     cur_cnt,
  input  logic [7:0]           char_byte,
  output flags_t               next_flags,
  output logic [CNT_W-1:0]     next_cnt,
  output result_t              res [RES_MAX],
  output logic [RES_IDX_W-1:0] res_num
);

  localparam int EXT_W = CNT_W + 7;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_TOKENS);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  // Build one result; the count is reported in its low bits
  function automatic result_t mk(kind_t k, logic [7:0] v, logic [CNT_W-1:0] cnt,
                                 logic with_num);
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] num_ext;
    result_t r;
    cnt_ext = EXT_W'(cnt);
    num_ext = (cnt == '0) ? '0 : EXT_W'(cnt - ONE);
    r.kind = k;
    r.value = v;
    r.token_number = with_num ? num_ext[5:0] : 6'd0;
    r.token_count = cnt_ext[6:0];
    return r;
  endfunction

  logic is_nul, is_ws, is_quote, is_slash, is_star;
  logic do_tb, do_eol;

  assign is_nul   = (char_byte == CHAR_NUL);
  assign is_ws    = !is_nul && (char_byte <= CHAR_SPACE);
  assign is_quote = (char_byte == CHAR_QUOTE);
  assign is_slash = (char_byte == CHAR_SLASH);
  assign is_star  = (char_byte == CHAR_STAR);

  // Work through the byte in the order the results come out
  always_comb begin
    next_flags = cur_flags;
    next_cnt   = cur_cnt;
    res_num    = '0;
    do_tb      = 1'b0;
    do_eol     = 1'b0;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '0;
    end

    unique case (cur_flags.mode)
      MODE_WS: begin
        if (cur_flags.slash) begin
          next_flags.slash = 1'b0;
          if (is_slash) begin
            next_flags.mode = MODE_DONE;
          end else if (is_star) begin
            next_flags.mode = MODE_BLOCK;
            next_flags.star = 1'b1;
          end else begin
            // held slash becomes the first byte of a new token
            next_cnt = next_cnt + ONE;
            next_flags.mode = MODE_TOKEN;
            res[res_num] = mk(KIND_BYTE, CHAR_SLASH, next_cnt, 1'b1);
            res_num = res_num + 1'b1;
            do_tb = 1'b1;
          end
        end else if (is_nul) begin
          do_eol = 1'b1;
        end else if (is_ws) begin
          next_flags.mode = MODE_WS;
        end else if (is_slash) begin
          next_flags.slash = 1'b1;
        end else if (is_quote) begin
          next_cnt = next_cnt + ONE;
          next_flags.mode = MODE_QUOTED;
        end else begin
          next_cnt = next_cnt + ONE;
          next_flags.mode = MODE_TOKEN;
          res[res_num] = mk(KIND_BYTE, char_byte, next_cnt, 1'b1);
          res_num = res_num + 1'b1;
        end
      end
      MODE_TOKEN: begin
        if (cur_flags.slash) begin
          next_flags.slash = 1'b0;
          if (is_slash || is_star) begin
            // comment opener closes the token first
            res[res_num] = mk(KIND_END_TOKEN, 8'h00, next_cnt, 1'b1);
            res_num = res_num + 1'b1;
            if (is_slash || next_cnt >= LIMIT) begin
              next_flags.mode = MODE_DONE;
            end else begin
              next_flags.mode = MODE_BLOCK;
              next_flags.star = 1'b1;
            end
          end else begin
            res[res_num] = mk(KIND_BYTE, CHAR_SLASH, next_cnt, 1'b1);
            res_num = res_num + 1'b1;
            do_tb = 1'b1;
          end
        end else begin
          do_tb = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (is_nul || is_quote) begin
          res[res_num] = mk(KIND_END_TOKEN, 8'h00, next_cnt, 1'b1);
          res_num = res_num + 1'b1;
          next_flags.mode = (next_cnt >= LIMIT) ? MODE_DONE : MODE_WS;
          do_eol = is_nul;
        end else begin
          res[res_num] = mk(KIND_BYTE, char_byte, next_cnt, 1'b1);
          res_num = res_num + 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (is_nul) begin
          do_eol = 1'b1;
        end else if (is_slash && cur_flags.star) begin
          next_flags.star = 1'b0;
          next_flags.mode = MODE_WS;
        end else begin
          next_flags.star = is_star;
        end
      end
      MODE_DONE: begin
        do_eol = is_nul;
      end
      default: begin
        do_eol = is_nul;
      end
    endcase

    // Byte inside a regular token with no slash held back
    if (do_tb) begin
      if (is_nul || is_ws || is_quote) begin
        res[res_num] = mk(KIND_END_TOKEN, 8'h00, next_cnt, 1'b1);
        res_num = res_num + 1'b1;
        next_flags.mode = (next_cnt >= LIMIT) ? MODE_DONE : MODE_WS;
        if (is_quote && next_cnt < LIMIT) begin
          next_cnt = next_cnt + ONE;
          next_flags.mode = MODE_QUOTED;
        end
        do_eol = is_nul;
      end else if (is_slash) begin
        next_flags.slash = 1'b1;
      end else begin
        res[res_num] = mk(KIND_BYTE, char_byte, next_cnt, 1'b1);
        res_num = res_num + 1'b1;
      end
    end

    // End of line: report the count, then back to the reset state
    if (do_eol) begin
      res[res_num] = mk(KIND_END_LINE, 8'h00, next_cnt, 1'b0);
      res_num = res_num + 1'b1;
      next_flags.mode = MODE_WS;
      next_flags.slash = 1'b0;
      next_flags.star = 1'b0;
      next_cnt = '0;
    end
  end

endmodule

// ----- design/command_line_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Path: each byte is held in the input register, its results in the result buffer.
// Throughput: one byte per cycle while each byte yields at most one result and
//   results are accepted; a byte with N results holds the input while they drain.
// Reset: synchronous rst clears the input register, result buffer and parser
//   state (skipping whitespace, no slash held, no tokens).
// ----------------------------------------------------------------------------
module command_line_tokenizer import cltok_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  cltok_char_if.sink  chars,
  cltok_res_if.source results
);

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);

  // Input register
  logic       in_vld;
  logic [7:0] in_byte;

  // Parser state
  flags_t           flags, flags_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Result buffer
  result_t              res_buf [RES_MAX];
  result_t              step_res [RES_MAX];
  logic [RES_IDX_W-1:0] res_cnt, step_num, rd_ptr;

  logic out_valid, out_last, drain_ok, advance;

  cltok_step #(
    .MAX_TOKENS (MAX_TOKENS),
    .CNT_W      (CNT_W)
  ) u_step (
    .cur_flags  (flags),
    .cur_cnt    (cnt),
    .char_byte  (in_byte),
    .next_flags (flags_next),
    .next_cnt   (cnt_next),
    .res        (step_res),
    .res_num    (step_num)
  );

  // Handshake: the buffer refills on the cycle its last result leaves
  assign out_valid = (rd_ptr != res_cnt);
  assign out_last  = (rd_ptr + 1'b1 == res_cnt);
  assign drain_ok  = !out_valid || (results.ready && out_last);
  assign advance   = in_vld && drain_ok;
  assign chars.ready = !in_vld || advance;

  assign results.valid        = out_valid;
  assign results.kind         = res_buf[rd_ptr].kind;
  assign results.value        = res_buf[rd_ptr].value;
  assign results.token_number = res_buf[rd_ptr].token_number;
  assign results.token_count  = res_buf[rd_ptr].token_count;
  assign results.last         = out_last;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.ready) begin
      in_vld <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready) begin
      in_byte <= chars.char_byte;
    end
  end

  // Parser state and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '{mode: MODE_WS, slash: 1'b0, star: 1'b0};
      cnt     <= '0;
      res_cnt <= '0;
      rd_ptr  <= '0;
    end else if (advance) begin
      flags   <= flags_next;
      cnt     <= cnt_next;
      res_cnt <= step_num;
      rd_ptr  <= '0;
    end else if (out_valid && results.ready) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_buf <= step_res;
    end
  end

endmodule

// ----- design/cltok_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_checker
// Port-level checks on the tokenizer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_macros.svh"

module cltok_checker import cltok_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [7:0] value,
  input logic [5:0] token_number,
  input logic [6:0] token_count,
  input logic       last
);

  // A stalled result transaction keeps its payload
  `CLTOK_ASSERT(a_stall_hold, res_valid && !res_ready |=> res_valid && $stable({kind, value, token_number, token_count, last}), "result changed while stalled")

  // Nothing comes out right after reset
  `CLTOK_ASSERT_ALWAYS(a_reset_quiet, rst |=> !res_valid, "result valid after reset")

  // Only the three result kinds are produced
  `CLTOK_ASSERT(a_kind_legal, res_valid |-> kind == KIND_BYTE || kind == KIND_END_TOKEN || kind == KIND_END_LINE, "illegal result kind")

  // End of line always closes the byte's results and carries token number zero
  `CLTOK_ASSERT(a_eol_last, res_valid && kind == KIND_END_LINE |-> last && token_number == 6'd0, "end of line not last")

  // Only token bytes carry a value
  `CLTOK_ASSERT(a_value_zero, res_valid && kind != KIND_BYTE |-> value == 8'h00, "value set on non-byte result")

endmodule

bind command_line_tokenizer cltok_checker u_cltok_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .kind         (results.kind),
  .value        (results.value),
  .token_number (results.token_number),
  .token_count  (results.token_count),
  .last         (results.last)
);
